@@ hdl/hcr_pkg.sv @@
// ----------------------------------------------------------------------------
// hcr_pkg
// Shared types, constants and codes of the Harris corner response block.
// ----------------------------------------------------------------------------
package hcr_pkg;

    // frame geometry
    localparam int MAX_WIDTH   = 640;
    localparam int MAX_HEIGHT  = 480;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int WIDTH_W     = 10;
    localparam int HEIGHT_W    = 9;

    localparam logic [WIDTH_W-1:0]  MIN_WIDTH_V  = WIDTH_W'(4);
    localparam logic [WIDTH_W-1:0]  MAX_WIDTH_V  = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] MIN_HEIGHT_V = HEIGHT_W'(4);
    localparam logic [HEIGHT_W-1:0] MAX_HEIGHT_V = HEIGHT_W'(MAX_HEIGHT);
    localparam logic [ADDR_W-1:0]   RESET_TOTAL  = ADDR_W'(STORE_DEPTH);

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // gray conversion
    localparam int GRAY_SUM_W = 22;
    localparam int PR_W       = 21;
    localparam int PG_W       = 22;
    localparam int PB_W       = 19;
    localparam logic [12:0] COEF_R = 13'd4899;
    localparam logic [13:0] COEF_G = 14'd9617;
    localparam logic [10:0] COEF_B = 11'd1868;
    localparam logic [GRAY_SUM_W-1:0] GRAY_ROUND = GRAY_SUM_W'(8192);

    // datapath widths
    localparam int PIX_W  = 8;
    localparam int GRAD_W = 11;
    localparam int PROD_W = 22;
    localparam int ACC_W  = 26;
    localparam int TR_W   = 27;
    localparam int MUL_W  = 54;
    localparam int RESP_W = 55;
    localparam int NUM_W  = 56;
    localparam int REM_W  = 64;
    localparam int QUO_W  = 8;
    localparam int BIT_W  = 3;

    // per pixel sequence: taps issued in steps 0..8, trace at 11,
    // products at 12, write back at 13
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_TAPS  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_TRACE = 4'd11;
    localparam logic [STEP_W-1:0] STEP_MUL   = 4'd12;
    localparam logic [STEP_W-1:0] STEP_LAST  = 4'd13;
    localparam logic [1:0]        TAP_LAST   = 2'd2;
    localparam logic [1:0]        TAP_MID    = 2'd1;
    localparam logic [BIT_W-1:0]  BIT_TOP    = 3'd7;

    typedef enum logic [1:0] {
        PASS_BLUR,
        PASS_GRAD,
        PASS_MOMENT
    } pass_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_BLUR,
        ST_GRAD,
        ST_MOMENT,
        ST_FETCH,
        ST_PREP,
        ST_DIVIDE,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic  load;
        logic  pass_start;
        pass_t pass_sel;
        logic  pass_run;
        logic  frame_done;
        logic  read_issue;
        logic  read_fetch;
        logic  div_prep;
        logic  div_step;
        logic  out_load;
        logic  out_zero;
    } cmd_t;

    typedef struct packed {
        logic load_last;
        logic pass_done;
        logic div_done;
    } status_t;

endpackage

@@ hdl/harris_corner_response.sv @@
// load beats are accepted back to back while idle; the final pixel of a frame starts
// a compute run (a flush step, then the blur, gradient and moment sweeps over every
// pixel, each on one store read port) during which no beat is accepted
// read beats return a result through fetch, prepare, the 8-step divider and result;
// a read before any frame is computed returns zero on the next cycle
// reset clears control, selects a 640x480 frame; pixel stores hold nothing valid
// ----------------------------------------------------------------------------
// harris_corner_response
// Harris corner response engine with min-max normalized readout.
// ----------------------------------------------------------------------------
module harris_corner_response (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           opcode,
    input  logic [7:0]                     blue,
    input  logic [7:0]                     green,
    input  logic [7:0]                     red,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     corner_value,
    output logic                           frame_ready,
    output logic                           last_pixel,
    input  logic                           cfg_we,
    input  logic [hcr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hcr_pkg::CFG_DATA_W-1:0] cfg_data
);

    hcr_pkg::cmd_t    cmd;
    hcr_pkg::status_t status;

    hcr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_we    (cfg_we),
        .status    (status),
        .cmd       (cmd)
    );

    hcr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .blue         (blue),
        .green        (green),
        .red          (red),
        .cmd          (cmd),
        .status       (status),
        .corner_value (corner_value),
        .frame_ready  (frame_ready),
        .last_pixel   (last_pixel)
    );

endmodule

@@ hdl/hcr_ram.sv @@
// ----------------------------------------------------------------------------
// hcr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module hcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/hcr_ctrl.sv @@
// ----------------------------------------------------------------------------
// hcr_ctrl
// Sequencer: handshakes, frame compute passes and the normalizing divide.
// ----------------------------------------------------------------------------
module hcr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             opcode,
    output logic             out_valid,
    input  logic             out_ready,
    input  logic             cfg_we,
    input  hcr_pkg::status_t status,
    output hcr_pkg::cmd_t    cmd
);

    hcr_pkg::state_t state_reg, state_next;
    logic computed_reg, computed_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;
    logic accept;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == hcr_pkg::ST_IDLE) && ((opcode == hcr_pkg::OP_LOAD) || out_free);
    assign accept   = in_valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hcr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == hcr_pkg::OP_LOAD)
                    begin
                        if (status.load_last)
                        begin
                            state_next = hcr_pkg::ST_FLUSH;
                        end
                    end
                    else if (computed_reg)
                    begin
                        state_next = hcr_pkg::ST_FETCH;
                    end
                end
            end
            hcr_pkg::ST_FLUSH:
            begin
                state_next = hcr_pkg::ST_BLUR;
            end
            hcr_pkg::ST_BLUR:
            begin
                if (status.pass_done)
                begin
                    state_next = hcr_pkg::ST_GRAD;
                end
            end
            hcr_pkg::ST_GRAD:
            begin
                if (status.pass_done)
                begin
                    state_next = hcr_pkg::ST_MOMENT;
                end
            end
            hcr_pkg::ST_MOMENT:
            begin
                if (status.pass_done)
                begin
                    state_next = hcr_pkg::ST_IDLE;
                end
            end
            hcr_pkg::ST_FETCH:
            begin
                state_next = hcr_pkg::ST_PREP;
            end
            hcr_pkg::ST_PREP:
            begin
                state_next = hcr_pkg::ST_DIVIDE;
            end
            hcr_pkg::ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = hcr_pkg::ST_RESULT;
                end
            end
            hcr_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = hcr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hcr_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd            = '0;
        cmd.pass_sel   = hcr_pkg::PASS_BLUR;
        computed_next  = computed_reg;
        unique case (state_reg)
            hcr_pkg::ST_IDLE:
            begin
                cmd.load       = accept && (opcode == hcr_pkg::OP_LOAD);
                cmd.read_issue = accept && (opcode == hcr_pkg::OP_READ) && computed_reg;
                cmd.out_zero   = accept && (opcode == hcr_pkg::OP_READ) && !computed_reg;
            end
            hcr_pkg::ST_FLUSH:
            begin
                cmd.pass_start = 1'b1;
                cmd.pass_sel   = hcr_pkg::PASS_BLUR;
            end
            hcr_pkg::ST_BLUR:
            begin
                cmd.pass_run   = 1'b1;
                cmd.pass_start = status.pass_done;
                cmd.pass_sel   = hcr_pkg::PASS_GRAD;
            end
            hcr_pkg::ST_GRAD:
            begin
                cmd.pass_run   = 1'b1;
                cmd.pass_start = status.pass_done;
                cmd.pass_sel   = hcr_pkg::PASS_MOMENT;
            end
            hcr_pkg::ST_MOMENT:
            begin
                cmd.pass_run   = 1'b1;
                cmd.frame_done = status.pass_done;
                if (status.pass_done)
                begin
                    computed_next = 1'b1;
                end
            end
            hcr_pkg::ST_FETCH:
            begin
                cmd.read_fetch = 1'b1;
            end
            hcr_pkg::ST_PREP:
            begin
                cmd.div_prep = 1'b1;
            end
            hcr_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            hcr_pkg::ST_RESULT:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
        if (cfg_we)
        begin
            computed_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load || cmd.out_zero)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hcr_pkg::ST_IDLE;
            computed_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            computed_reg  <= computed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ hdl/hcr_dp.sv @@
// ----------------------------------------------------------------------------
// hcr_dp
// Datapath: frame stores, 3x3 window scan, blur, gradient, moment and
// response arithmetic, min/max tracking and the restoring divider.
// ----------------------------------------------------------------------------
module hcr_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [hcr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hcr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [7:0]                       blue,
    input  logic [7:0]                       green,
    input  logic [7:0]                       red,
    input  hcr_pkg::cmd_t                    cmd,
    output hcr_pkg::status_t                 status,
    output logic [7:0]                       corner_value,
    output logic                             frame_ready,
    output logic                             last_pixel
);

    localparam int AW = hcr_pkg::ADDR_W;

    // ------------------------------------------------------------ geometry
    logic [hcr_pkg::WIDTH_W-1:0]  width_reg;
    logic [hcr_pkg::HEIGHT_W-1:0] height_reg;
    logic [AW-1:0]                total_reg;
    logic [hcr_pkg::WIDTH_W-1:0]  width_next;
    logic [hcr_pkg::HEIGHT_W-1:0] height_next;

    always_comb
    begin
        width_next  = cfg_data[hcr_pkg::WIDTH_W-1:0];
        height_next = cfg_data[hcr_pkg::HEIGHT_W-1:0];
        if (width_next < hcr_pkg::MIN_WIDTH_V)
        begin
            width_next = hcr_pkg::MIN_WIDTH_V;
        end
        else if (width_next > hcr_pkg::MAX_WIDTH_V)
        begin
            width_next = hcr_pkg::MAX_WIDTH_V;
        end
        if (height_next < hcr_pkg::MIN_HEIGHT_V)
        begin
            height_next = hcr_pkg::MIN_HEIGHT_V;
        end
        else if (height_next > hcr_pkg::MAX_HEIGHT_V)
        begin
            height_next = hcr_pkg::MAX_HEIGHT_V;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= hcr_pkg::MAX_WIDTH_V;
            height_reg <= hcr_pkg::MAX_HEIGHT_V;
            total_reg  <= hcr_pkg::RESET_TOTAL;
        end
        else
        begin
            if (cfg_we && (cfg_index == hcr_pkg::CFG_FRAME_WIDTH))
            begin
                width_reg <= width_next;
            end
            if (cfg_we && (cfg_index == hcr_pkg::CFG_FRAME_HEIGHT))
            begin
                height_reg <= height_next;
            end
            total_reg <= AW'(AW'(width_reg) * AW'(height_reg));
        end
    end

    // ------------------------------------------------------------ loading
    logic [AW-1:0]                     load_pos_reg;
    logic                              ld_valid_reg;
    logic [AW-1:0]                     ld_addr_reg;
    logic [hcr_pkg::PR_W-1:0]          pr_reg;
    logic [hcr_pkg::PG_W-1:0]          pg_reg;
    logic [hcr_pkg::PB_W-1:0]          pb_reg;
    logic [hcr_pkg::GRAY_SUM_W-1:0]    gray_sum;
    logic                              load_last;

    assign load_last = (load_pos_reg == total_reg - AW'(1));
    assign gray_sum  = hcr_pkg::GRAY_SUM_W'(pr_reg) + hcr_pkg::GRAY_SUM_W'(pg_reg)
                     + hcr_pkg::GRAY_SUM_W'(pb_reg) + hcr_pkg::GRAY_ROUND;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pos_reg <= '0;
            ld_valid_reg <= 1'b0;
        end
        else
        begin
            ld_valid_reg <= cmd.load;
            if (cfg_we)
            begin
                load_pos_reg <= '0;
            end
            else if (cmd.load)
            begin
                load_pos_reg <= load_last ? '0 : load_pos_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ld_addr_reg <= load_pos_reg;
            pr_reg      <= hcr_pkg::PR_W'(red)   * hcr_pkg::PR_W'(hcr_pkg::COEF_R);
            pg_reg      <= hcr_pkg::PG_W'(green) * hcr_pkg::PG_W'(hcr_pkg::COEF_G);
            pb_reg      <= hcr_pkg::PB_W'(blue)  * hcr_pkg::PB_W'(hcr_pkg::COEF_B);
        end
    end

    // ------------------------------------------------------------ window scan
    hcr_pkg::pass_t               pass_reg;
    logic [hcr_pkg::STEP_W-1:0]   step_reg;
    logic [1:0]                   trow_reg;
    logic [1:0]                   tcol_reg;
    logic [hcr_pkg::WIDTH_W-1:0]  x_reg;
    logic [hcr_pkg::HEIGHT_W-1:0] y_reg;
    logic [AW-1:0]                base_reg;
    logic [AW-1:0]                up_reg;
    logic [AW-1:0]                dn_reg;
    logic                         first_reg;
    logic                         issuing;
    logic                         step_end;
    logic                         row_end;
    logic                         frame_end;
    logic [hcr_pkg::WIDTH_W-1:0]  tap_col;
    logic [AW-1:0]                tap_row;
    logic [AW-1:0]                tap_addr;
    logic [AW-1:0]                pix_addr;
    logic [AW-1:0]                base_down;

    assign issuing   = cmd.pass_run && (step_reg < hcr_pkg::STEP_TAPS);
    assign step_end  = cmd.pass_run && (step_reg == hcr_pkg::STEP_LAST);
    assign row_end   = (x_reg == width_reg - hcr_pkg::WIDTH_W'(1));
    assign frame_end = row_end && (y_reg == height_reg - hcr_pkg::HEIGHT_W'(1));
    assign pix_addr  = base_reg + AW'(x_reg);
    assign base_down = base_reg + AW'(width_reg);

    // reflect-101 column and row of the current tap
    always_comb
    begin
        unique case (tcol_reg)
            2'd0:    tap_col = (x_reg == '0) ? hcr_pkg::WIDTH_W'(1) : x_reg - hcr_pkg::WIDTH_W'(1);
            2'd2:    tap_col = row_end ? width_reg - hcr_pkg::WIDTH_W'(2)
                                       : x_reg + hcr_pkg::WIDTH_W'(1);
            default: tap_col = x_reg;
        endcase
        unique case (trow_reg)
            2'd0:    tap_row = up_reg;
            2'd2:    tap_row = dn_reg;
            default: tap_row = base_reg;
        endcase
    end

    assign tap_addr = tap_row + AW'(tap_col);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_reg  <= hcr_pkg::PASS_BLUR;
            step_reg  <= '0;
            trow_reg  <= '0;
            tcol_reg  <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            base_reg  <= '0;
            up_reg    <= '0;
            dn_reg    <= '0;
            first_reg <= 1'b0;
        end
        else if (cmd.pass_start)
        begin
            pass_reg  <= cmd.pass_sel;
            step_reg  <= '0;
            trow_reg  <= '0;
            tcol_reg  <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            base_reg  <= '0;
            up_reg    <= AW'(width_reg);
            dn_reg    <= AW'(width_reg);
            first_reg <= 1'b1;
        end
        else if (cmd.pass_run)
        begin
            step_reg <= step_end ? '0 : step_reg + hcr_pkg::STEP_W'(1);
            if (issuing)
            begin
                if (tcol_reg == hcr_pkg::TAP_LAST)
                begin
                    tcol_reg <= '0;
                    trow_reg <= (trow_reg == hcr_pkg::TAP_LAST) ? 2'd0 : trow_reg + 2'd1;
                end
                else
                begin
                    tcol_reg <= tcol_reg + 2'd1;
                end
            end
            if (step_end)
            begin
                if (pass_reg == hcr_pkg::PASS_MOMENT)
                begin
                    first_reg <= 1'b0;
                end
                if (row_end)
                begin
                    x_reg    <= '0;
                    y_reg    <= y_reg + hcr_pkg::HEIGHT_W'(1);
                    base_reg <= base_down;
                    up_reg   <= base_reg;
                    dn_reg   <= (y_reg == height_reg - hcr_pkg::HEIGHT_W'(2))
                                ? base_reg : base_down + AW'(width_reg);
                end
                else
                begin
                    x_reg <= x_reg + hcr_pkg::WIDTH_W'(1);
                end
            end
        end
    end

    // ------------------------------------------------------------ stores
    logic [hcr_pkg::PIX_W-1:0]      gray_rd;
    logic [hcr_pkg::PIX_W-1:0]      smooth_rd;
    logic [2*hcr_pkg::GRAD_W-1:0]   grad_rd;
    logic [hcr_pkg::RESP_W-1:0]     resp_rd;
    logic [hcr_pkg::PIX_W-1:0]      smooth_wdata;
    logic [2*hcr_pkg::GRAD_W-1:0]   grad_wdata;
    logic signed [hcr_pkg::RESP_W-1:0] resp_val;
    logic [AW-1:0]                  read_pos_reg;
    logic                           smooth_we;
    logic                           grad_we;
    logic                           resp_we;

    assign smooth_we = step_end && (pass_reg == hcr_pkg::PASS_BLUR);
    assign grad_we   = step_end && (pass_reg == hcr_pkg::PASS_GRAD);
    assign resp_we   = step_end && (pass_reg == hcr_pkg::PASS_MOMENT);

    hcr_ram #(.WIDTH(hcr_pkg::PIX_W), .DEPTH(hcr_pkg::STORE_DEPTH)) u_gray_ram (
        .clk   (clk),
        .we    (ld_valid_reg),
        .waddr (ld_addr_reg),
        .wdata (gray_sum[hcr_pkg::GRAY_SUM_W-1 -: hcr_pkg::PIX_W]),
        .raddr (tap_addr),
        .rdata (gray_rd)
    );

    hcr_ram #(.WIDTH(hcr_pkg::PIX_W), .DEPTH(hcr_pkg::STORE_DEPTH)) u_smooth_ram (
        .clk   (clk),
        .we    (smooth_we),
        .waddr (pix_addr),
        .wdata (smooth_wdata),
        .raddr (tap_addr),
        .rdata (smooth_rd)
    );

    hcr_ram #(.WIDTH(2*hcr_pkg::GRAD_W), .DEPTH(hcr_pkg::STORE_DEPTH)) u_grad_ram (
        .clk   (clk),
        .we    (grad_we),
        .waddr (pix_addr),
        .wdata (grad_wdata),
        .raddr (tap_addr),
        .rdata (grad_rd)
    );

    hcr_ram #(.WIDTH(hcr_pkg::RESP_W), .DEPTH(hcr_pkg::STORE_DEPTH)) u_resp_ram (
        .clk   (clk),
        .we    (resp_we),
        .waddr (pix_addr),
        .wdata (resp_val),
        .raddr (read_pos_reg),
        .rdata (resp_rd)
    );

    // ------------------------------------------------------------ tap pipeline
    logic                              iss_v_reg;
    logic [1:0]                        iss_row_reg;
    logic [1:0]                        iss_col_reg;
    logic                              a_v_reg;
    logic [1:0]                        a_row_reg;
    logic [1:0]                        a_col_reg;
    logic [hcr_pkg::PIX_W-1:0]         a_pix_reg;
    logic signed [hcr_pkg::PROD_W-1:0] pxx_reg;
    logic signed [hcr_pkg::PROD_W-1:0] pyy_reg;
    logic signed [hcr_pkg::PROD_W-1:0] pxy_reg;
    logic signed [hcr_pkg::GRAD_W-1:0] gx_rd;
    logic signed [hcr_pkg::GRAD_W-1:0] gy_rd;

    assign gx_rd = grad_rd[2*hcr_pkg::GRAD_W-1 -: hcr_pkg::GRAD_W];
    assign gy_rd = grad_rd[hcr_pkg::GRAD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_v_reg <= 1'b0;
            a_v_reg   <= 1'b0;
        end
        else
        begin
            iss_v_reg <= issuing;
            a_v_reg   <= iss_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        iss_row_reg <= trow_reg;
        iss_col_reg <= tcol_reg;
        a_row_reg   <= iss_row_reg;
        a_col_reg   <= iss_col_reg;
        a_pix_reg   <= (pass_reg == hcr_pkg::PASS_BLUR) ? gray_rd : smooth_rd;
        pxx_reg     <= hcr_pkg::PROD_W'(gx_rd) * hcr_pkg::PROD_W'(gx_rd);
        pyy_reg     <= hcr_pkg::PROD_W'(gy_rd) * hcr_pkg::PROD_W'(gy_rd);
        pxy_reg     <= hcr_pkg::PROD_W'(gx_rd) * hcr_pkg::PROD_W'(gy_rd);
    end

    // ------------------------------------------------------------ accumulate
    logic signed [hcr_pkg::ACC_W-1:0] acc_a_reg;
    logic signed [hcr_pkg::ACC_W-1:0] acc_b_reg;
    logic signed [hcr_pkg::ACC_W-1:0] acc_c_reg;
    logic signed [hcr_pkg::ACC_W-1:0] acc_a_next;
    logic signed [hcr_pkg::ACC_W-1:0] acc_b_next;
    logic signed [hcr_pkg::ACC_W-1:0] acc_c_next;
    logic signed [hcr_pkg::ACC_W-1:0] pix_ext;
    logic signed [hcr_pkg::ACC_W-1:0] mag_x;
    logic signed [hcr_pkg::ACC_W-1:0] mag_y;
    logic [1:0]                       wshift;
    logic [hcr_pkg::ACC_W-1:0]        blur_round;

    assign pix_ext = $signed(hcr_pkg::ACC_W'(a_pix_reg));
    assign wshift  = 2'((a_row_reg == hcr_pkg::TAP_MID)) + 2'((a_col_reg == hcr_pkg::TAP_MID));
    assign mag_x   = (a_row_reg == hcr_pkg::TAP_MID) ? (pix_ext <<< 1) : pix_ext;
    assign mag_y   = (a_col_reg == hcr_pkg::TAP_MID) ? (pix_ext <<< 1) : pix_ext;

    always_comb
    begin
        acc_a_next = acc_a_reg;
        acc_b_next = acc_b_reg;
        acc_c_next = acc_c_reg;
        if (cmd.pass_run && (step_reg == '0))
        begin
            acc_a_next = '0;
            acc_b_next = '0;
            acc_c_next = '0;
        end
        else if (a_v_reg)
        begin
            unique case (pass_reg)
                hcr_pkg::PASS_BLUR:
                begin
                    acc_a_next = acc_a_reg + (pix_ext <<< wshift);
                end
                hcr_pkg::PASS_GRAD:
                begin
                    // left column subtracts, right column adds; top row subtracts for gy
                    if (a_col_reg == 2'd0)
                    begin
                        acc_a_next = acc_a_reg - mag_x;
                    end
                    else if (a_col_reg == hcr_pkg::TAP_LAST)
                    begin
                        acc_a_next = acc_a_reg + mag_x;
                    end
                    if (a_row_reg == 2'd0)
                    begin
                        acc_b_next = acc_b_reg - mag_y;
                    end
                    else if (a_row_reg == hcr_pkg::TAP_LAST)
                    begin
                        acc_b_next = acc_b_reg + mag_y;
                    end
                end
                hcr_pkg::PASS_MOMENT:
                begin
                    acc_a_next = acc_a_reg + (hcr_pkg::ACC_W'(pxx_reg) <<< wshift);
                    acc_b_next = acc_b_reg + (hcr_pkg::ACC_W'(pyy_reg) <<< wshift);
                    acc_c_next = acc_c_reg + (hcr_pkg::ACC_W'(pxy_reg) <<< wshift);
                end
                default:
                begin
                    acc_a_next = acc_a_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        acc_a_reg <= acc_a_next;
        acc_b_reg <= acc_b_next;
        acc_c_reg <= acc_c_next;
    end

    assign blur_round   = acc_a_reg + hcr_pkg::ACC_W'(8);
    assign smooth_wdata = blur_round[hcr_pkg::PIX_W+3:4];
    assign grad_wdata   = {acc_a_reg[hcr_pkg::GRAD_W-1:0], acc_b_reg[hcr_pkg::GRAD_W-1:0]};

    // ------------------------------------------------------------ response
    logic signed [hcr_pkg::TR_W-1:0]   tr_reg;
    logic signed [hcr_pkg::MUL_W-1:0]  m1_reg;
    logic signed [hcr_pkg::MUL_W-1:0]  m2_reg;
    logic signed [hcr_pkg::MUL_W-1:0]  m3_reg;
    logic signed [hcr_pkg::RESP_W-1:0] det_diff;
    logic signed [hcr_pkg::RESP_W-1:0] min_reg;
    logic signed [hcr_pkg::RESP_W-1:0] max_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.pass_run && (step_reg == hcr_pkg::STEP_TRACE))
        begin
            tr_reg <= hcr_pkg::TR_W'(acc_a_reg) + hcr_pkg::TR_W'(acc_b_reg);
        end
        if (cmd.pass_run && (step_reg == hcr_pkg::STEP_MUL))
        begin
            m1_reg <= hcr_pkg::MUL_W'(acc_a_reg) * hcr_pkg::MUL_W'(acc_b_reg);
            m2_reg <= hcr_pkg::MUL_W'(acc_c_reg) * hcr_pkg::MUL_W'(acc_c_reg);
            m3_reg <= hcr_pkg::MUL_W'(tr_reg) * hcr_pkg::MUL_W'(tr_reg);
        end
    end

    // 25 * (det) - trace^2
    assign det_diff = hcr_pkg::RESP_W'(m1_reg) - hcr_pkg::RESP_W'(m2_reg);
    assign resp_val = (det_diff <<< 4) + (det_diff <<< 3) + det_diff - hcr_pkg::RESP_W'(m3_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '0;
            max_reg <= '0;
        end
        else if (resp_we)
        begin
            if (first_reg || (resp_val < min_reg))
            begin
                min_reg <= resp_val;
            end
            if (first_reg || (resp_val > max_reg))
            begin
                max_reg <= resp_val;
            end
        end
    end

    // ------------------------------------------------------------ readout
    logic                          rd_last_reg;
    logic                          read_last;
    logic [hcr_pkg::NUM_W-1:0]     num_reg;
    logic [hcr_pkg::NUM_W-1:0]     den_reg;
    logic                          flat_reg;
    logic [hcr_pkg::REM_W-1:0]     rem_reg;
    logic [hcr_pkg::QUO_W-1:0]     quo_reg;
    logic [hcr_pkg::BIT_W-1:0]     bit_reg;
    logic [hcr_pkg::REM_W-1:0]     trial;
    logic signed [hcr_pkg::NUM_W-1:0] num_s;
    logic signed [hcr_pkg::NUM_W-1:0] den_s;
    logic signed [hcr_pkg::RESP_W-1:0] resp_rd_s;
    logic [7:0]                    corner_value_reg;
    logic                          frame_ready_reg;
    logic                          last_pixel_reg;

    assign read_last = (read_pos_reg == total_reg - AW'(1));
    assign resp_rd_s = $signed(resp_rd);
    assign num_s     = hcr_pkg::NUM_W'(resp_rd_s) - hcr_pkg::NUM_W'(min_reg);
    assign den_s     = hcr_pkg::NUM_W'(max_reg) - hcr_pkg::NUM_W'(min_reg);
    assign trial     = hcr_pkg::REM_W'(den_reg) << bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_pos_reg <= '0;
            rd_last_reg  <= 1'b0;
            bit_reg      <= '0;
        end
        else
        begin
            if (cfg_we || cmd.frame_done)
            begin
                read_pos_reg <= '0;
            end
            else if (cmd.read_issue)
            begin
                read_pos_reg <= read_last ? '0 : read_pos_reg + AW'(1);
                rd_last_reg  <= read_last;
            end
            if (cmd.div_prep)
            begin
                bit_reg <= hcr_pkg::BIT_TOP;
            end
            else if (cmd.div_step)
            begin
                bit_reg <= bit_reg - hcr_pkg::BIT_W'(1);
            end
        end
    end

    // restoring divide, one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.read_fetch)
        begin
            num_reg  <= num_s;
            den_reg  <= den_s;
            flat_reg <= (max_reg == min_reg);
        end
        if (cmd.div_prep)
        begin
            rem_reg <= {num_reg, 8'b0} - hcr_pkg::REM_W'(num_reg)
                     + hcr_pkg::REM_W'(den_reg >> 1);
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg          <= rem_reg - trial;
                quo_reg[bit_reg] <= 1'b1;
            end
        end
        if (cmd.out_load)
        begin
            corner_value_reg <= flat_reg ? 8'd0 : quo_reg;
            frame_ready_reg  <= 1'b1;
            last_pixel_reg   <= rd_last_reg;
        end
        else if (cmd.out_zero)
        begin
            corner_value_reg <= 8'd0;
            frame_ready_reg  <= 1'b0;
            last_pixel_reg   <= 1'b0;
        end
    end

    assign corner_value = corner_value_reg;
    assign frame_ready  = frame_ready_reg;
    assign last_pixel   = last_pixel_reg;

    assign status.load_last = load_last;
    assign status.pass_done = step_end && frame_end;
    assign status.div_done  = (bit_reg == '0);

endmodule
